// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the echo ranging block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define UER_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/uer_pkg.sv =====
// Package with types and constants of the ultrasonic echo ranging block.
`default_nettype none

package uer_pkg;

    localparam int COUNT_BITS = 24;
    localparam int TRIG_BITS  = 8;
    localparam int DIST_BITS  = 25;
    localparam int REM_BITS   = 4;
    localparam int CFG_BITS   = 24;
    localparam int IN_BITS    = 8;
    localparam int OUT_BITS   = 56;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [COUNT_BITS-1:0] RST_PERIOD  = COUNT_BITS'(2000000);
    localparam logic [TRIG_BITS-1:0]  RST_TRIGGER = TRIG_BITS'(10);
    localparam logic [COUNT_BITS-1:0] RST_TIMEOUT = COUNT_BITS'(1000000);
    localparam logic                  RST_LEVEL   = 1'b1;

    // Distance is width * 17 / 10: each width tick adds 1 to the quotient
    // and 7 to the remainder in tenths.
    localparam logic [REM_BITS:0]   REM_STEP = (REM_BITS+1)'(7);
    localparam logic [REM_BITS:0]   REM_BASE = (REM_BITS+1)'(10);

    typedef enum logic [1:0] {
        CFG_PERIOD  = 2'd0,
        CFG_TRIGGER = 2'd1,
        CFG_TIMEOUT = 2'd2,
        CFG_LEVEL   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_TRIG       = 3'd1,
        PH_WAIT_END   = 3'd2,
        PH_WAIT_START = 3'd3,
        PH_MEASURE    = 3'd4
    } t_phase;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
    } t_dist_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/uer_dist_acc.sv =====
// Running width-to-distance converter that tracks width * 17 / 10.
`default_nettype none

module uer_dist_acc
    import uer_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_dist_ctl            i_ctl,
    output logic [DIST_BITS-1:0]      o_dist
);

    logic [DIST_BITS-1:0] r_quot;
    logic [REM_BITS-1:0]  r_rem;
    logic [DIST_BITS-1:0] n_quot;
    logic [REM_BITS-1:0]  n_rem;
    logic [REM_BITS:0]    rem_sum;

    always_comb begin
        rem_sum = {1'b0, r_rem} + REM_STEP;
        n_quot  = r_quot;
        n_rem   = r_rem;
        priority if (i_ctl.clear) begin
            n_quot = '0;
            n_rem  = '0;
        end else if (i_ctl.load) begin
            n_quot = DIST_BITS'(1);
            n_rem  = REM_STEP[REM_BITS-1:0];
        end else if (i_ctl.step) begin
            // A carry out of the tenths adds one more to the quotient.
            if (rem_sum >= REM_BASE) begin
                n_quot = r_quot + DIST_BITS'(2);
                n_rem  = REM_BITS'(rem_sum - REM_BASE);
            end else begin
                n_quot = r_quot + DIST_BITS'(1);
                n_rem  = rem_sum[REM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_dist = r_quot;

endmodule

`default_nettype wire

// ===== rtl/core/ultrasonic_echo_ranging.sv =====
// Ultrasonic echo ranging controller: trigger, echo wait, width and distance.
// A result word appears on the output in the cycle after its input word is accepted.
// Throughput: one input word per cycle while the result side is not stalled, one result word per input word.
// The output register decouples the sides; input ready falls only on a stall.
// Reset (synchronous, active low) sets phase idle, counters zero, registers
// to their defaults, and empties the output register.
`default_nettype none

module ultrasonic_echo_ranging
    import uer_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_addr,
    input  wire logic [CFG_BITS-1:0]   i_cfg_data,
    // Input stream.
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_BITS-1:0]    i_s_axis_tdata,  // [0] echo_level
    // Result stream.
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [0] trigger_out, [1] done_res, [2] timed_out, [26:3] pulse_width_us,
    // [51:27] distance_centi_cm, [55:52] zero
    output logic [OUT_BITS-1:0]        o_m_axis_tdata
);

    `include "assert_macros.svh"

    // Configuration registers.
    logic [COUNT_BITS-1:0] r_period_ticks;
    logic [TRIG_BITS-1:0]  r_trigger_ticks;
    logic [COUNT_BITS-1:0] r_timeout_ticks;
    logic                  r_pulse_level;

    // Measurement state.
    t_phase                r_phase,  n_phase;
    logic [COUNT_BITS-1:0] r_period, n_period;
    logic [TRIG_BITS-1:0]  r_trig_cnt, n_trig_cnt;
    logic [COUNT_BITS-1:0] r_elapsed, n_elapsed;
    logic [COUNT_BITS-1:0] r_width, n_width;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]   r_out_data,  n_out_data;

    logic                  accept;
    logic                  active;
    logic                  timed;
    logic [COUNT_BITS-1:0] period_inc;
    logic [TRIG_BITS:0]    trig_inc;
    logic                  trig;
    logic                  done;
    logic                  tmo;
    logic                  report;
    logic [COUNT_BITS-1:0] width_out;
    logic [DIST_BITS-1:0]  dist_out;
    logic [DIST_BITS-1:0]  acc_dist;
    t_dist_ctl             dist_ctl;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    uer_dist_acc u_dist (
        .i_clk  (i_clk),
        .i_ctl  (dist_ctl),
        .o_dist (acc_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ticks  <= RST_PERIOD;
            r_trigger_ticks <= RST_TRIGGER;
            r_timeout_ticks <= RST_TIMEOUT;
            r_pulse_level   <= RST_LEVEL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PERIOD:  r_period_ticks  <= i_cfg_data[COUNT_BITS-1:0];
                CFG_TRIGGER: r_trigger_ticks <= i_cfg_data[TRIG_BITS-1:0];
                CFG_TIMEOUT: r_timeout_ticks <= i_cfg_data[COUNT_BITS-1:0];
                CFG_LEVEL:   r_pulse_level   <= i_cfg_data[0];
                default:     r_pulse_level   <= r_pulse_level;
            endcase
        end
    end

    always_comb begin
        active     = (i_s_axis_tdata[0] == r_pulse_level);
        timed      = (r_elapsed >= r_timeout_ticks);
        period_inc = (r_period == COUNT_MAX) ? COUNT_MAX : r_period + COUNT_BITS'(1);
        trig_inc   = {1'b0, r_trig_cnt} + (TRIG_BITS+1)'(1);

        n_phase    = r_phase;
        n_period   = period_inc;
        n_trig_cnt = r_trig_cnt;
        n_elapsed  = r_elapsed;
        n_width    = r_width;
        trig       = 1'b0;
        done       = 1'b0;
        tmo        = 1'b0;
        report     = 1'b0;
        dist_ctl   = '0;

        unique case (r_phase)
            PH_TRIG: begin
                trig       = 1'b1;
                n_trig_cnt = trig_inc[TRIG_BITS-1:0];
                if (trig_inc >= {1'b0, r_trigger_ticks}) begin
                    n_phase   = PH_WAIT_END;
                    n_elapsed = '0;
                end
            end
            PH_WAIT_END: begin
                if (active) begin
                    if (timed) begin
                        done = 1'b1;
                        tmo  = 1'b1;
                    end
                end else begin
                    n_phase = PH_WAIT_START;
                end
            end
            PH_WAIT_START: begin
                if (active) begin
                    n_phase       = PH_MEASURE;
                    n_width       = COUNT_BITS'(1);
                    dist_ctl.load = 1'b1;
                end else if (timed) begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end
            end
            PH_MEASURE: begin
                if (active) begin
                    if (timed) begin
                        done = 1'b1;
                        tmo  = 1'b1;
                    end else if (r_width != COUNT_MAX) begin
                        // The width saturates, and the distance stops with it.
                        n_width       = r_width + COUNT_BITS'(1);
                        dist_ctl.step = 1'b1;
                    end
                end else begin
                    done   = 1'b1;
                    report = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (period_inc >= r_period_ticks) begin
                    n_period   = '0;
                    trig       = 1'b1;
                    n_trig_cnt = TRIG_BITS'(1);
                    if (r_trigger_ticks <= TRIG_BITS'(1)) begin
                        n_phase   = PH_WAIT_END;
                        n_elapsed = '0;
                    end else begin
                        n_phase = PH_TRIG;
                    end
                end
            end
        endcase

        // Timeout time runs on every wait tick, not on the last trigger tick.
        if (!trig && (n_phase == PH_WAIT_END || n_phase == PH_WAIT_START ||
                      n_phase == PH_MEASURE)) begin
            n_elapsed = (n_elapsed == COUNT_MAX) ? COUNT_MAX
                                                 : n_elapsed + COUNT_BITS'(1);
        end
        if (done) begin
            n_phase        = PH_IDLE;
            n_width        = '0;
            n_elapsed      = '0;
            dist_ctl.clear = 1'b1;
        end

        width_out = report ? r_width  : '0;
        dist_out  = report ? acc_dist : '0;

        if (!accept) begin
            n_phase    = r_phase;
            n_period   = r_period;
            n_trig_cnt = r_trig_cnt;
            n_elapsed  = r_elapsed;
            n_width    = r_width;
            dist_ctl   = '0;
        end

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        if (accept) begin
            n_out_valid = 1'b1;
            n_out_data  = {(OUT_BITS-DIST_BITS-COUNT_BITS-3)'(0), dist_out, width_out,
                           tmo, done, trig};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_period    <= '0;
            r_trig_cnt  <= '0;
            r_elapsed   <= '0;
            r_width     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_period    <= n_period;
            r_trig_cnt  <= n_trig_cnt;
            r_elapsed   <= n_elapsed;
            r_width     <= n_width;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `UER_ASSERT_IMPL(a_done_no_trig, r_out_valid && r_out_data[1], !r_out_data[0], "done word also drives the trigger")
    `UER_ASSERT_IMPL(a_tmo_zero_width, r_out_valid && r_out_data[2], r_out_data[1] && (r_out_data[26:3] == '0) && (r_out_data[51:27] == '0), "timeout word without done or with nonzero width")
    `UER_ASSERT_IMPL(a_width_in_measure, r_phase != PH_MEASURE, r_width == '0, "width counter nonzero outside the measure phase")
    `UER_ASSERT_NEXT(a_result_follows, accept, r_out_valid, "accepted word left no result word")

endmodule

`default_nettype wire
